>>> rtl/tcgr_pkg.sv
// Shared constants and types for the text console glyph renderer.
// No dependencies; imported by text_console_glyph_renderer_core.
`timescale 1ns / 1ps
`default_nettype none

package tcgr_pkg;

   // Default console geometry.
   localparam int TEXT_COLUMNS_DEF  = 50;
   localparam int LAST_TEXT_ROW_DEF = 29;

   // Field widths.
   localparam int CODE_W   = 8;
   localparam int GROW_W   = 3;
   localparam int BITS_W   = 8;
   localparam int PIX_W    = 17;
   localparam int COL_W    = 6;
   localparam int ROW_W    = 5;
   localparam int FONT_AW  = CODE_W + GROW_W;
   localparam int FONT_DEPTH = 1 << FONT_AW;
   localparam int STEP_W   = 6;
   localparam int REQ_DW   = 24;
   localparam int RSP_DW   = 24;

   // Request kinds (carried on tuser).
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_RENDER = 1'b1;

   // Control characters.
   localparam logic [CODE_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CODE_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CODE_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [CODE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CODE_W-1:0] CHAR_SPACE = 8'h20;

   // Last step of a 64-pixel glyph sweep.
   localparam logic [STEP_W-1:0] STEP_LAST = 6'h3F;
   localparam logic [GROW_W-1:0] GY_LAST   = 3'h7;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_BASE = 5'b00100,
      ST_RUN  = 5'b01000,
      ST_FLAG = 5'b10000
   } state_type;

endpackage

`default_nettype wire

>>> rtl/text_console_glyph_renderer_core.sv
// Top level of the text console glyph renderer: cursor, font store and pixel sequencer.
// Depends on tcgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Text console renderer for a framebuffer stored rotated, column by column.
// A request with tuser = 0 stores one 8-bit row of one glyph in the 2048 x 8
// font store. A request with tuser = 1 is a character: printable codes produce
// 64 pixel write responses, glyph column outer and glyph row inner, and then
// advance the cursor with wrap at TEXT_COLUMNS. Newline and carriage return
// move only the cursor; NUL changes nothing. A backspace away from column 0
// steps back one column and redraws a space there with the same 64-write
// sweep, leaving the cursor on that column; at column 0 it does nothing.
// Passing the last text row raises scroll_up instead of moving memory; a
// newline that scrolls gives a single response with write_valid low.
// A printable character or a redrawing backspace passes through the column
// multiply (ST_MUL), the base address (ST_BASE) and 64 writes (ST_RUN), one
// per cycle while rsp_tready does not stall, and returns to ST_IDLE, which
// takes the next request. A scrolling newline passes through ST_FLAG; other
// requests are finished in ST_IDLE. The pixel address comes from one shared
// adder stepping through the glyph, and the glyph rows come from the single
// read port of the font store, one row per cycle during the first glyph column
// while the output is not stalled, buffered for the other seven. Font rows
// that were never loaded read as undefined data. The block takes no new
// request while a character is being drawn.
module text_console_glyph_renderer_core
   import tcgr_pkg::*;
#(
   parameter int TEXT_COLUMNS  = TEXT_COLUMNS_DEF,
   parameter int LAST_TEXT_ROW = LAST_TEXT_ROW_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   input  wire logic [REQ_DW-1:0] req_tdata,  // char_code[7:0], glyph_row[10:8], row_bits[18:11]
   input  wire logic              req_tuser,  // mode[0]
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   output      logic [RSP_DW-1:0] rsp_tdata,  // pixel_index[16:0], lit[17]
   output      logic [1:0]        rsp_tuser,  // write_valid[0], scroll_up[1]
   output      logic              rsp_tlast   // last
);

   // Geometry derived from the parameters.
   localparam int PIXEL_ROWS = (LAST_TEXT_ROW + 1) * 8;
   localparam int COL_STRIDE = 8 * PIXEL_ROWS;           // pixels per text column
   localparam logic [10:0]      COL_STRIDE_V = 11'(COL_STRIDE);
   localparam logic [7:0]       ROW_TOP      = 8'(PIXEL_ROWS - 1);
   localparam logic [PIX_W-1:0] NEXT_COL_STEP = PIX_W'(PIXEL_ROWS + 7);
   localparam logic [PIX_W-1:0] PIX_LIMIT    = PIX_W'(TEXT_COLUMNS * COL_STRIDE);
   localparam logic [COL_W:0]   COLS_V       = (COL_W + 1)'(TEXT_COLUMNS);
   localparam logic [ROW_W-1:0] LAST_ROW_V   = ROW_W'(LAST_TEXT_ROW);

   // Request fields.
   logic              in_mode;
   logic [CODE_W-1:0] in_code;
   logic [GROW_W-1:0] in_grow;
   logic [BITS_W-1:0] in_bits;

   assign in_mode = req_tuser;
   assign in_code = req_tdata[7:0];
   assign in_grow = req_tdata[10:8];
   assign in_bits = req_tdata[18:11];

   // State.
   state_type         state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              print_ff, print_in;    // printable: advance cursor at end
   logic [STEP_W-1:0] step_ff, step_in;      // {glyph column, glyph row}
   logic [PIX_W-1:0]  prod_ff, prod_in;      // cursor column * COL_STRIDE
   logic [PIX_W-1:0]  pix_ff, pix_in;        // pixel index of the current step

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pix_ff, rsp_pix_in;
   logic              rsp_lit_ff, rsp_lit_in;
   logic              rsp_wv_ff, rsp_wv_in;
   logic              rsp_scroll_ff, rsp_scroll_in;
   logic              rsp_last_ff, rsp_last_in;

   // Font store and glyph row buffer.
   logic [BITS_W-1:0] font_mem [FONT_DEPTH];
   logic [BITS_W-1:0] rd_data_ff;
   logic [BITS_W-1:0] rows_ff [8];

   logic              accept;
   logic              out_free;
   logic              emit;
   logic              load_we;
   logic [2:0]        gx;
   logic [GROW_W-1:0] gy;
   logic [GROW_W-1:0] rd_row;
   logic [FONT_AW-1:0] rd_addr;
   logic [BITS_W-1:0] cur_row_bits;
   logic              wrap;
   logic              row_at_last;
   logic [7:0]        row_off;
   logic [PIX_W-1:0]  add_a, add_b, add_sum;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load_we    = accept && (in_mode == MODE_LOAD);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit       = (state_ff == ST_RUN) && out_free;

   assign gx = step_ff[5:3];
   assign gy = step_ff[2:0];

   // Read one row ahead so rd_data_ff always holds row gy while drawing.
   assign rd_row  = emit ? (gy + 3'd1) : gy;
   assign rd_addr = {code_ff, rd_row};

   // Column 0 takes rows straight from the store; later columns reuse them.
   assign cur_row_bits = (gx == 3'd0) ? rd_data_ff : rows_ff[gy];

   assign wrap        = ({1'b0, col_ff} + 7'd1) >= COLS_V;
   assign row_at_last = row_ff >= LAST_ROW_V;

   // Shared adder: base address setup, then step down a column or to the next one.
   assign row_off = ROW_TOP - {row_ff, 3'b000};
   assign add_a   = (state_ff == ST_BASE) ? prod_ff : pix_ff;
   always_comb begin
      if (state_ff == ST_BASE) begin
         add_b = {9'd0, row_off};
      end else if (gy == GY_LAST) begin
         add_b = NEXT_COL_STEP;
      end else begin
         add_b = '1;                             // minus one
      end
   end
   assign add_sum = add_a + add_b;

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      code_in       = code_ff;
      print_in      = print_ff;
      step_in       = step_ff;
      prod_in       = prod_ff;
      pix_in        = pix_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_pix_in    = rsp_pix_ff;
      rsp_lit_in    = rsp_lit_ff;
      rsp_wv_in     = rsp_wv_ff;
      rsp_scroll_in = rsp_scroll_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (in_mode == MODE_RENDER)) begin
               unique case (in_code)
                  CHAR_NL: begin
                     col_in = '0;
                     if (row_at_last) begin
                        state_in = ST_FLAG;
                     end else begin
                        row_in = row_ff + 5'd1;
                     end
                  end
                  CHAR_CR: begin
                     col_in = '0;
                  end
                  CHAR_NUL: begin
                  end
                  CHAR_BS: begin
                     if (col_ff != '0) begin
                        col_in   = col_ff - 6'd1;
                        code_in  = CHAR_SPACE;
                        print_in = 1'b0;
                        step_in  = '0;
                        state_in = ST_MUL;
                     end
                  end
                  default: begin
                     code_in  = in_code;
                     print_in = 1'b1;
                     step_in  = '0;
                     state_in = ST_MUL;
                  end
               endcase
            end
         end
         ST_MUL: begin
            prod_in  = PIX_W'(col_ff) * PIX_W'(COL_STRIDE_V);
            state_in = ST_BASE;
         end
         ST_BASE: begin
            pix_in   = add_sum;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (emit) begin
               rsp_valid_in  = 1'b1;
               rsp_pix_in    = pix_ff;
               rsp_lit_in    = cur_row_bits[gx];
               rsp_wv_in     = 1'b1;
               rsp_scroll_in = 1'b0;
               rsp_last_in   = 1'b0;
               pix_in        = add_sum;
               step_in       = step_ff + 6'd1;
               if (step_ff == STEP_LAST) begin
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
                  if (print_ff) begin
                     // cursor advance with wrap; scroll on the last row
                     if (wrap) begin
                        col_in = '0;
                        if (row_at_last) begin
                           row_in        = LAST_ROW_V;
                           rsp_scroll_in = 1'b1;
                        end else begin
                           row_in = row_ff + 5'd1;
                        end
                     end else begin
                        col_in = col_ff + 6'd1;
                     end
                  end
               end
            end
         end
         ST_FLAG: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pix_in    = '0;
               rsp_lit_in    = 1'b0;
               rsp_wv_in     = 1'b0;
               rsp_scroll_in = 1'b1;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      print_ff      <= print_in;
      prod_ff       <= prod_in;
      pix_ff        <= pix_in;
      rsp_pix_ff    <= rsp_pix_in;
      rsp_lit_ff    <= rsp_lit_in;
      rsp_wv_ff     <= rsp_wv_in;
      rsp_scroll_ff <= rsp_scroll_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Font store: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (load_we) begin
         font_mem[{in_code, in_grow}] <= in_bits;
      end
      rd_data_ff <= font_mem[rd_addr];
   end

   // Keep glyph rows seen during the first column.
   always_ff @(posedge clock) begin
      if (emit && (gx == 3'd0)) begin
         rows_ff[gy] <= rd_data_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_lit_ff, rsp_pix_ff};
   assign rsp_tuser  = {rsp_scroll_ff, rsp_wv_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Cursor never leaves the screen.
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= LAST_ROW_V)
      else $error("cursor row past last text row");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < COLS_V)
      else $error("cursor column past text width");

   // A response without a pixel write is only the scroll marker of a newline.
   a_flag_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_wv_ff |-> rsp_scroll_ff && rsp_last_ff)
      else $error("non-write response is not a final scroll request");

   // Pixel writes stay inside the framebuffer.
   a_pix_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_wv_ff |-> rsp_pix_ff < PIX_LIMIT)
      else $error("pixel index outside framebuffer");

   // The 64th write of a glyph ends the sweep and frees the input.
   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      emit && (step_ff == STEP_LAST) |=> req_tready && rsp_valid_ff && rsp_last_ff)
      else $error("glyph sweep did not close on its last write");

endmodule

`default_nettype wire
